FILE: rtl/core/sbs_pkg.sv
// Shared types and the per-probe decision for the sorted array binary search.
// No dependencies.
package sbs_pkg;

  typedef enum logic [2:0] {
    MODE_LOAD     = 3'd0,
    MODE_FIRST_EQ = 3'd1,
    MODE_LAST_EQ  = 3'd2,
    MODE_LOWER    = 3'd3,
    MODE_UPPER    = 3'd4
  } mode_e;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned PosW   = 10;
  localparam int unsigned CountW = 11;

  typedef struct packed {
    mode_e                   mode;
    logic [PosW-1:0]         pos;
    logic signed [KeyW-1:0]  key;
  } item_t;

  typedef struct packed {
    logic take;
    logic go_left;
  } step_t;

  function automatic step_t decide(logic signed [KeyW-1:0] data,
                                   logic signed [KeyW-1:0] key, mode_e mode);
    step_t d;
    logic  lt;
    logic  eq;
    lt = data < key;
    eq = data == key;
    case (mode)
      MODE_FIRST_EQ: begin
        d.take    = eq;
        d.go_left = !lt;
      end
      MODE_LAST_EQ: begin
        d.take    = eq;
        d.go_left = !lt && !eq;
      end
      MODE_LOWER: begin
        d.take    = !lt;
        d.go_left = !lt;
      end
      default: begin
        d.take    = !lt && !eq;
        d.go_left = !lt && !eq;
      end
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/core/sbs_in_if.sv
// Input channel of the sorted array binary search: handshake plus item word.
// Depends on sbs_pkg.
interface sbs_in_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          mode;
  logic [sbs_pkg::PosW-1:0]            position;
  logic signed [sbs_pkg::KeyW-1:0]     key;
  modport source (output valid, mode, position, key, input ready);
  modport sink   (input valid, mode, position, key, output ready);
endinterface

FILE: rtl/core/sbs_out_if.sv
// Output channel of the sorted array binary search: handshake plus result word.
// Depends on sbs_pkg.
interface sbs_out_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [sbs_pkg::PosW-1:0]  match_position;
  modport source (output valid, found, match_position, input ready);
  modport sink   (input valid, found, match_position, output ready);
endinterface

FILE: rtl/core/sbs_step.sv
// One search stage: resolve the previous probe, then probe its own copy of the store.
// Loads write this copy as they pass. Depends on sbs_pkg.
module sbs_step #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned CW    = 11,
  parameter int unsigned AW    = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               adv_i,
  input  logic                               vld_i,
  input  sbs_pkg::item_t                     item_i,
  input  logic                               act_i,
  input  logic signed [CW:0]                 lft_i,
  input  logic signed [CW:0]                 rgt_i,
  input  logic signed [CW:0]                 res_i,
  input  logic signed [CW:0]                 mid_i,
  input  logic signed [sbs_pkg::KeyW-1:0]    data_i,
  output logic                               vld_o,
  output sbs_pkg::item_t                     item_o,
  output logic                               act_o,
  output logic signed [CW:0]                 lft_o,
  output logic signed [CW:0]                 rgt_o,
  output logic signed [CW:0]                 res_o,
  output logic signed [CW:0]                 mid_o,
  output logic signed [sbs_pkg::KeyW-1:0]    data_o
);

  logic [sbs_pkg::KeyW-1:0] mem [DEPTH];
  sbs_pkg::step_t           dec;
  logic signed [CW:0]       lft_d, rgt_d, res_d, mid_d;
  logic                     act_d;
  logic                     is_load;
  logic                     vld_q, act_q;
  sbs_pkg::item_t           item_q;
  logic signed [CW:0]       lft_q, rgt_q, res_q, mid_q;
  logic signed [sbs_pkg::KeyW-1:0] data_q;

  assign is_load = item_i.mode == sbs_pkg::MODE_LOAD;

  always_comb begin
    dec   = sbs_pkg::decide(data_i, item_i.key, item_i.mode);
    lft_d = lft_i;
    rgt_d = rgt_i;
    res_d = res_i;
    if (act_i) begin
      if (dec.take) res_d = mid_i;
      if (dec.go_left) rgt_d = mid_i - (CW+1)'(1);
      else lft_d = mid_i + (CW+1)'(1);
    end
    act_d = !is_load && (lft_d <= rgt_d);
    mid_d = lft_d + ((rgt_d - lft_d) >>> 1);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && vld_i && is_load && (32'(item_i.pos) < DEPTH)) begin
      mem[AW'(item_i.pos)] <= item_i.key;
    end
    if (adv_i) begin
      data_q <= mem[AW'(mid_d)];
      item_q <= item_i;
      lft_q  <= lft_d;
      rgt_q  <= rgt_d;
      res_q  <= res_d;
      mid_q  <= mid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      act_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
      act_q <= vld_i && act_d;
    end
  end

  assign vld_o  = vld_q;
  assign act_o  = act_q;
  assign item_o = item_q;
  assign lft_o  = lft_q;
  assign rgt_o  = rgt_q;
  assign res_o  = res_q;
  assign mid_o  = mid_q;
  assign data_o = data_q;

endmodule

FILE: rtl/core/sbs_out.sv
// Output stage: resolve the last probe and hold the result word for the sink.
// Depends on sbs_pkg.
module sbs_out #(
  parameter int unsigned CW = 11
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  logic                            vld_i,
  input  sbs_pkg::item_t                  item_i,
  input  logic                            act_i,
  input  logic signed [CW:0]              res_i,
  input  logic signed [CW:0]              mid_i,
  input  logic signed [sbs_pkg::KeyW-1:0] data_i,
  output logic                            valid_o,
  output logic                            found_o,
  output logic [sbs_pkg::PosW-1:0]        pos_o
);

  sbs_pkg::step_t     dec;
  logic signed [CW:0] res_d;
  logic               valid_q, found_q;
  logic [sbs_pkg::PosW-1:0] pos_q;

  always_comb begin
    dec   = sbs_pkg::decide(data_i, item_i.key, item_i.mode);
    res_d = (act_i && dec.take) ? mid_i : res_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      found_q <= !res_d[CW];
      pos_q   <= res_d[CW] ? '0 : sbs_pkg::PosW'(res_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= vld_i && (item_i.mode != sbs_pkg::MODE_LOAD);
    end
  end

  assign valid_o = valid_q;
  assign found_o = found_q;
  assign pos_o   = pos_q;

endmodule

FILE: rtl/core/sorted_array_binary_search.sv
// Sorted array binary search, top level. Depends on sbs_pkg, sbs_in_if, sbs_out_if,
// sbs_step and sbs_out.
// A word enters every cycle the output is free or being taken; a query passes one
// pipeline stage per halving probe, the last probe resolved into the result register.
// Each probe stage keeps its own copy of the store, written by loads as they pass, so
// loads and queries keep order.
module sorted_array_binary_search #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sbs_pkg::CountW-1:0]   cfg_data_i,
  sbs_in_if.sink                       in_if,
  sbs_out_if.source                    out_if
);

  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned STEPS = $clog2(DEPTH + 1);

  logic [sbs_pkg::CountW-1:0] count_q;
  logic                       adv;
  logic                       out_vld;
  logic [CW:0]                count_sat;

  logic                            vld  [STEPS+1];
  sbs_pkg::item_t                  item [STEPS+1];
  logic                            act  [STEPS+1];
  logic signed [CW:0]              lft  [STEPS+1];
  logic signed [CW:0]              rgt  [STEPS+1];
  logic signed [CW:0]              res  [STEPS+1];
  logic signed [CW:0]              mid  [STEPS+1];
  logic signed [sbs_pkg::KeyW-1:0] data [STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_data_i;
    end
  end

  assign adv         = !out_vld || out_if.ready;
  assign in_if.ready = adv;
  assign count_sat   = (32'(count_q) > DEPTH) ? (CW+1)'(DEPTH) : (CW+1)'(count_q);

  always_comb begin
    vld[0]       = in_if.valid && (in_if.mode <= 3'(sbs_pkg::MODE_UPPER));
    item[0].mode = sbs_pkg::mode_e'(in_if.mode);
    item[0].pos  = in_if.position;
    item[0].key  = in_if.key;
    act[0]       = 1'b0;
    lft[0]       = '0;
    rgt[0]       = $signed(count_sat) - (CW+1)'(1);
    res[0]       = '1;
    mid[0]       = '0;
    data[0]      = '0;
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    sbs_step #(.DEPTH(DEPTH), .CW(CW), .AW(AW)) u_step (
      .clk_i, .rst_ni, .adv_i(adv),
      .vld_i(vld[k]), .item_i(item[k]), .act_i(act[k]), .lft_i(lft[k]),
      .rgt_i(rgt[k]), .res_i(res[k]), .mid_i(mid[k]), .data_i(data[k]),
      .vld_o(vld[k+1]), .item_o(item[k+1]), .act_o(act[k+1]), .lft_o(lft[k+1]),
      .rgt_o(rgt[k+1]), .res_o(res[k+1]), .mid_o(mid[k+1]), .data_o(data[k+1])
    );
  end

  sbs_out #(.CW(CW)) u_out (
    .clk_i, .rst_ni, .adv_i(adv),
    .vld_i(vld[STEPS]), .item_i(item[STEPS]), .act_i(act[STEPS]),
    .res_i(res[STEPS]), .mid_i(mid[STEPS]), .data_i(data[STEPS]),
    .valid_o(out_vld), .found_o(out_if.found), .pos_o(out_if.match_position)
  );

  assign out_if.valid = out_vld;

endmodule

FILE: rtl/core/sbs_checker.sv
// Port-level checks for sorted_array_binary_search, attached by bind.
// Depends on sbs_pkg and the top level's ports only.
module sbs_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       found_i,
  input logic [sbs_pkg::PosW-1:0]   match_position_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(found_i)
      && $stable(match_position_i))
    else $error("result word changed while stalled");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !found_i |-> match_position_i == '0)
    else $error("not-found result carries a position");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

endmodule

bind sorted_array_binary_search sbs_checker u_sbs_checker (
  .clk_i, .rst_ni,
  .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid),
  .out_ready_i(out_if.ready),
  .found_i(out_if.found),
  .match_position_i(out_if.match_position)
);

FILE: tb/tb.sv
// Testbench for sorted_array_binary_search: loads ascending arrays, runs queries in all four
// search modes and checks each result word against an in-bench predictor or a table row.
// Depends on sbs_pkg, sbs_in_if, sbs_out_if and the RTL top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned LIMIT = 2000000;

  typedef struct {
    logic [2:0]               mode;
    logic [sbs_pkg::PosW-1:0] pos;
    logic [sbs_pkg::KeyW-1:0] key;
    bit                       has_exp;
    logic                     exp_found;
    logic [sbs_pkg::PosW-1:0] exp_pos;
  } row_t;

  typedef struct {
    logic                     found;
    logic [sbs_pkg::PosW-1:0] pos;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [sbs_pkg::CountW-1:0] cfg_data_i = '0;

  sbs_in_if in_if ();
  sbs_out_if out_if ();

  sorted_array_binary_search #(.DEPTH(DEPTH)) i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i),
    .in_if(in_if.sink), .out_if(out_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic signed [sbs_pkg::KeyW-1:0] store_model [DEPTH];
  int unsigned            count_model;
  answer_t                pending_answers[$];
  answer_t                typed_answers[$];
  bit                     typed_flags[$];
  int unsigned            errors = 0;
  int unsigned            cycles = 0;
  int unsigned            accepted = 0;
  int unsigned            seen = 0;
  int unsigned            sink_wait = 0;
  bit                     stim_done = 0;

  function automatic answer_t search_answer(logic [2:0] mode,
                                            logic signed [sbs_pkg::KeyW-1:0] key);
    answer_t a;
    int left, right, mid, res, cnt;
    logic lt, eq, take, go_left;
    cnt = (count_model > DEPTH) ? DEPTH : count_model;
    left = 0;
    right = cnt - 1;
    res = -1;
    while (left <= right) begin
      mid = (left + right) / 2;
      lt = store_model[mid] < key;
      eq = store_model[mid] == key;
      case (mode)
        sbs_pkg::MODE_FIRST_EQ: begin take = eq; go_left = !lt; end
        sbs_pkg::MODE_LAST_EQ: begin take = eq; go_left = !lt && !eq; end
        sbs_pkg::MODE_LOWER: begin take = !lt; go_left = !lt; end
        default: begin take = !lt && !eq; go_left = take; end
      endcase
      if (take) res = mid;
      if (go_left) right = mid - 1;
      else left = mid + 1;
    end
    a.found = (res >= 0);
    a.pos = (res >= 0) ? res[sbs_pkg::PosW-1:0] : '0;
    return a;
  endfunction

  task automatic send_word(row_t r);
    answer_t a;
    int unsigned w;
    w = $urandom_range(0, 6);
    if (w != 0) begin
      in_if.valid <= 1'b0;
      repeat (w) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.mode <= r.mode;
    in_if.position <= r.pos;
    in_if.key <= r.key;
    do @(posedge clk_i); while (!in_if.ready);
    if (r.mode == sbs_pkg::MODE_LOAD) begin
      store_model[r.pos] = r.key;
    end else if (r.mode <= sbs_pkg::MODE_UPPER) begin
      a = search_answer(r.mode, r.key);
      pending_answers.push_back(a);
      typed_flags.push_back(r.has_exp);
      if (r.has_exp) begin
        typed_answers.push_back('{r.exp_found, r.exp_pos});
        if (a.found !== r.exp_found || a.pos !== r.exp_pos)
          $error("table row disagrees with predictor for mode %0d key %0d", r.mode, r.key);
      end
    end
    @(negedge clk_i);
  endtask

  task automatic drain_and_config(int unsigned n);
    in_if.valid <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    cfg_data_i <= n[sbs_pkg::CountW-1:0];
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    count_model = n;
  endtask

  function automatic row_t mk(logic [2:0] m, int p, logic [sbs_pkg::KeyW-1:0] k);
    row_t r;
    r.mode = m;
    r.pos = p[sbs_pkg::PosW-1:0];
    r.key = k;
    r.has_exp = 0;
    r.exp_found = 0;
    r.exp_pos = '0;
    return r;
  endfunction

  function automatic row_t mkx(logic [2:0] m, logic [sbs_pkg::KeyW-1:0] k, logic f, int p);
    row_t r;
    r = mk(m, 0, k);
    r.has_exp = 1;
    r.exp_found = f;
    r.exp_pos = p[sbs_pkg::PosW-1:0];
    return r;
  endfunction

  // load n ascending values, possibly with runs of duplicates
  task automatic load_sorted(int unsigned n, bit full_range);
    logic signed [sbs_pkg::KeyW-1:0] v;
    v = full_range ? 32'sh8000_0000 : $signed($urandom_range(0, 40)) - 20;
    for (int unsigned i = 0; i < n; i++) begin
      send_word(mk(sbs_pkg::MODE_LOAD, i, v));
      if ($urandom_range(0, 2) != 0) begin
        if (full_range && i == n - 2) v = 32'sh7fff_ffff;
        else if (full_range) v = v + $signed($urandom_range(1, 32'h3fff_ffff / n));
        else v = v + $signed($urandom_range(1, 3));
      end
    end
  endtask

  task automatic random_query();
    int unsigned cnt, idx;
    logic [2:0] m;
    logic signed [sbs_pkg::KeyW-1:0] k;
    cnt = (count_model > DEPTH) ? DEPTH : count_model;
    m = 3'($urandom_range(sbs_pkg::MODE_FIRST_EQ, sbs_pkg::MODE_UPPER));
    idx = (cnt == 0) ? 0 : $urandom_range(0, cnt - 1);
    case ($urandom_range(0, 3))
      0: k = $urandom();
      1: k = (cnt == 0) ? 0 : store_model[idx];
      default: k = (cnt == 0) ? 0 : store_model[idx] + $signed($urandom_range(0, 2)) - 1;
    endcase
    send_word(mk(m, $urandom_range(0, DEPTH - 1), k));
  endtask

  initial begin
    row_t table_rows[$];
    row_t noise;
    int unsigned n;
    in_if.valid = 1'b0;
    in_if.mode = '0;
    in_if.position = '0;
    in_if.key = '0;
    count_model = 0;
    foreach (store_model[i]) store_model[i] = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty array after reset
    table_rows.push_back(mkx(sbs_pkg::MODE_FIRST_EQ, 32'sd0, 0, 0));
    table_rows.push_back(mkx(sbs_pkg::MODE_UPPER, 32'sh8000_0000, 0, 0));
    table_rows.push_back(mk(3'd5, 0, 32'sd1));
    table_rows.push_back(mk(3'd7, 1023, 32'hffff_ffff));
    table_rows.push_back(mk(sbs_pkg::MODE_LOAD, 0, 32'sh8000_0000));
    table_rows.push_back(mk(sbs_pkg::MODE_LOAD, 1, 32'sd5));
    table_rows.push_back(mk(sbs_pkg::MODE_LOAD, 2, 32'sd5));
    table_rows.push_back(mk(sbs_pkg::MODE_LOAD, 3, 32'sh7fff_ffff));
    table_rows.push_back(mk(sbs_pkg::MODE_LOAD, 1023, 32'sh1234_5678));
    foreach (table_rows[i]) send_word(table_rows[i]);
    table_rows.delete();
    drain_and_config(4);
    table_rows.push_back(mkx(sbs_pkg::MODE_FIRST_EQ, 32'sd5, 1, 1));
    table_rows.push_back(mkx(sbs_pkg::MODE_LAST_EQ, 32'sd5, 1, 2));
    table_rows.push_back(mkx(sbs_pkg::MODE_LOWER, 32'sd5, 1, 1));
    table_rows.push_back(mkx(sbs_pkg::MODE_UPPER, 32'sd5, 1, 3));
    table_rows.push_back(mkx(sbs_pkg::MODE_FIRST_EQ, 32'sh8000_0000, 1, 0));
    table_rows.push_back(mkx(sbs_pkg::MODE_LAST_EQ, 32'sh7fff_ffff, 1, 3));
    table_rows.push_back(mkx(sbs_pkg::MODE_UPPER, 32'sh7fff_ffff, 0, 0));
    table_rows.push_back(mkx(sbs_pkg::MODE_LOWER, 32'sh8000_0000, 1, 0));
    table_rows.push_back(mkx(sbs_pkg::MODE_FIRST_EQ, 32'sd4, 0, 0));
    table_rows.push_back(mk(3'd6, 0, 32'sd5));
    // unsorted contents
    table_rows.push_back(mk(sbs_pkg::MODE_LOAD, 0, 32'sd9));
    table_rows.push_back(mk(sbs_pkg::MODE_LOWER, 0, 32'sd5));
    table_rows.push_back(mk(sbs_pkg::MODE_LAST_EQ, 0, 32'sd9));
    foreach (table_rows[i]) send_word(table_rows[i]);

    // full-store phase with extreme count, and count beyond store
    load_sorted(DEPTH, 1);
    drain_and_config(DEPTH);
    repeat (12) random_query();
    drain_and_config(2047);
    repeat (12) random_query();
    drain_and_config(0);
    repeat (3) random_query();

    for (int ph = 0; ph < 4; ph++) begin
      n = (ph % 4 == 0) ? 1 : $urandom_range(2, 8);
      drain_and_config(0);
      load_sorted(n, ph[0]);
      if ($urandom_range(0, 3) == 0) begin
        noise = mk(3'($urandom_range(5, 7)), $urandom_range(0, DEPTH - 1), $urandom());
        send_word(noise);
      end
      drain_and_config(n);
      repeat (6) random_query();
    end

    in_if.valid <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    stim_done = 1;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (accepted != seen) begin
        seen = accepted;
        sink_wait = $urandom_range(0, 6);
      end
      if (out_if.valid && sink_wait != 0) begin
        sink_wait--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    answer_t e;
    bit t;
    answer_t te;
    cycles <= cycles + 1;
    if (rst_ni && out_if.valid && out_if.ready) begin
      accepted++;
      if (pending_answers.size() == 0) begin
        $error("result word with no expectation waiting");
        errors++;
      end else begin
        e = pending_answers.pop_front();
        t = typed_flags.pop_front();
        if (t) begin
          te = typed_answers.pop_front();
          e = te;
        end
        if (out_if.found !== e.found) begin
          $error("found: expected %0d actual %0d", e.found, out_if.found);
          errors++;
        end
        if (out_if.match_position !== e.pos) begin
          $error("match_position: expected %0d actual %0d", e.pos, out_if.match_position);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (stim_done || cycles >= LIMIT);
    if (!stim_done) begin
      $display("Test completed with failures");
    end else if (errors == 0 && pending_answers.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
